// ===== rtl/core/gtl_pkg.sv =====
// Shared types, codes and helpers for the grammar token lexer.
package gtl_pkg;

	localparam int MAX_TEXT_CHARS_DEF = 8;

	// result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} char_word_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [63:0] token_text;
		logic [3:0]  token_length;
		logic        last_of_run;
	} token_word_t;

	typedef struct packed {
		logic [1:0]  n;
		token_word_t w0;
		token_word_t w1;
	} token_push_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_COMMENT = 3'd2,
		MODE_QOPEN   = 3'd3,
		MODE_QCLOSE  = 3'd4
	} lex_mode_t;

	localparam logic [3:0] KIND_ERROR  = 4'd0;
	localparam logic [3:0] KIND_OP     = 4'd1;
	localparam logic [3:0] KIND_PLAIN  = 4'd2;
	localparam logic [3:0] KIND_ALL    = 4'd5;
	localparam logic [3:0] KIND_REDUCE = 4'd6;
	localparam logic [3:0] KIND_SHIFT  = 4'd7;
	localparam logic [3:0] KIND_END    = 4'd8;

	localparam logic [1:0] CLS_PLAIN = 2'd0;
	localparam logic [1:0] CLS_VAR   = 2'd1;
	localparam logic [1:0] CLS_FUNC  = 2'd2;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	// keyword bodies, first character in low byte
	localparam logic [63:0] WORD_ALL    = 64'h0000_0000_004C_4C41;
	localparam logic [63:0] WORD_REDUCE = 64'h0000_4543_5544_4552;
	localparam logic [63:0] WORD_SHIFT  = 64'h0000_0054_4649_4853;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_body(input logic [7:0] c);
		return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic token_word_t mk_tok(input logic [3:0] kind, input logic [63:0] text,
		input logic [3:0] len);
		token_word_t t;
		t.token_kind   = kind;
		t.token_text   = text;
		t.token_length = len;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

endpackage

// ===== rtl/core/gtl_core.sv =====
// Lexer state registers and the per-character next-state and token logic.
module gtl_core import gtl_pkg::*; #(
	parameter int MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  char_word_t  ch,
	output token_push_t push
);

	lex_mode_t   mode_q, mode_d;
	logic [63:0] buf_q, buf_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [1:0]  cls_q, cls_d;

	logic [7:0]  c;
	logic        eoi;

	// handling of a character between tokens
	logic        st_v;
	token_word_t st_res;
	lex_mode_t   st_mode;
	logic        st_load;
	logic [63:0] st_buf;
	logic [3:0]  st_cnt;
	logic [1:0]  st_cls;

	token_word_t fin;
	logic        pre_v;
	token_word_t pre_res;
	logic        do_st;

	assign c   = ch.char_code;
	assign eoi = ch.end_of_input;

	always_comb begin
		st_v    = 1'b0;
		st_res  = mk_tok(KIND_ERROR, 64'd0, 4'd0);
		st_mode = MODE_IDLE;
		st_load = 1'b0;
		st_buf  = 64'd0;
		st_cnt  = 4'd0;
		st_cls  = CLS_PLAIN;
		priority if (eoi) begin
			st_v   = 1'b1;
			st_res = mk_tok(KIND_END, 64'd0, 4'd0);
		end else if (is_blank(c)) begin
			st_mode = MODE_IDLE;
		end else if (c == CH_HASH) begin
			st_mode = MODE_COMMENT;
		end else if (c == CH_EQ || c == CH_SEMI) begin
			st_v   = 1'b1;
			st_res = mk_tok(KIND_OP, {56'd0, c}, 4'd1);
		end else if (is_letter(c)) begin
			st_mode = MODE_IDENT;
			st_load = 1'b1;
			st_buf  = {56'd0, c};
			st_cnt  = 4'd1;
		end else if (c == CH_DOLLAR || c == CH_AMP) begin
			st_mode = MODE_IDENT;
			st_load = 1'b1;
			st_cls  = (c == CH_DOLLAR) ? CLS_VAR : CLS_FUNC;
		end else if (c == CH_QUOTE) begin
			st_mode = MODE_QOPEN;
		end else begin
			st_v   = 1'b1;
			st_res = mk_tok(KIND_ERROR, {56'd0, c}, 4'd1);
		end
	end

	// token for a finished identifier
	always_comb begin
		if (cnt_q == 4'd0) begin
			fin = mk_tok(KIND_ERROR, 64'd0, 4'd0);
		end else if (cnt_q == 4'd3 && buf_q == WORD_ALL) begin
			fin = mk_tok(KIND_ALL, buf_q, cnt_q);
		end else if (cnt_q == 4'd6 && buf_q == WORD_REDUCE) begin
			fin = mk_tok(KIND_REDUCE, buf_q, cnt_q);
		end else if (cnt_q == 4'd5 && buf_q == WORD_SHIFT) begin
			fin = mk_tok(KIND_SHIFT, buf_q, cnt_q);
		end else begin
			fin = mk_tok(KIND_PLAIN + {2'd0, cls_q}, buf_q, cnt_q);
		end
	end

	always_comb begin
		pre_v   = 1'b0;
		pre_res = mk_tok(KIND_ERROR, 64'd0, 4'd0);
		do_st   = 1'b0;
		mode_d  = mode_q;
		buf_d   = buf_q;
		cnt_d   = cnt_q;
		cls_d   = cls_q;
		unique case (mode_q)
			MODE_IDENT: begin
				if (!eoi && is_body(c) && cnt_q < 4'(MAX_TEXT_CHARS)) begin
					buf_d[{cnt_q[2:0], 3'b000} +: 8] = c;
					cnt_d = cnt_q + 4'd1;
				end else begin
					pre_v   = 1'b1;
					pre_res = fin;
					do_st   = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (eoi) begin
					do_st = 1'b1;
				end else if (c == CH_LF) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_QOPEN: begin
				if (eoi) begin
					pre_v   = 1'b1;
					pre_res = mk_tok(KIND_ERROR, 64'd0, 4'd0);
					do_st   = 1'b1;
				end else begin
					buf_d  = {56'd0, c};
					cnt_d  = 4'd1;
					cls_d  = CLS_PLAIN;
					mode_d = MODE_QCLOSE;
				end
			end
			MODE_QCLOSE: begin
				pre_v = 1'b1;
				if (!eoi && c == CH_QUOTE) begin
					pre_res = mk_tok(KIND_PLAIN, {56'd0, buf_q[7:0]}, 4'd1);
					mode_d  = MODE_IDLE;
				end else begin
					pre_res = mk_tok(KIND_ERROR, {56'd0, buf_q[7:0]}, 4'd1);
					do_st   = 1'b1;
				end
			end
			default: begin
				do_st = 1'b1;
			end
		endcase
		if (do_st) begin
			mode_d = st_mode;
			if (st_load) begin
				buf_d = st_buf;
				cnt_d = st_cnt;
				cls_d = st_cls;
			end
		end
	end

	// pack up to two tokens, last one flagged
	always_comb begin
		push.w0 = pre_v ? pre_res : st_res;
		push.w1 = st_res;
		if (pre_v && do_st && st_v) begin
			push.n = 2'd2;
			push.w1.last_of_run = 1'b1;
		end else if (pre_v || (do_st && st_v)) begin
			push.n = 2'd1;
			push.w0.last_of_run = 1'b1;
		end else begin
			push.n = 2'd0;
		end
		if (!fire) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			buf_q  <= 64'd0;
			cnt_q  <= 4'd0;
			cls_q  <= CLS_PLAIN;
		end else if (fire) begin
			mode_q <= mode_d;
			buf_q  <= buf_d;
			cnt_q  <= cnt_d;
			cls_q  <= cls_d;
		end
	end

	a_eoi_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi |=> mode_q == MODE_IDLE)
		else $error("end of input did not return lexer to idle");

	a_eoi_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi |-> push.n != 2'd0)
		else $error("end of input produced no token");

	a_ident_len: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDENT |-> cnt_q <= 4'(MAX_TEXT_CHARS))
		else $error("identifier body longer than limit");

endmodule

// ===== rtl/core/gtl_queue.sv =====
// Four-entry token queue taking up to two tokens per cycle, giving one per cycle unless token_stall holds it.
module gtl_queue import gtl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  token_push_t push,
	output logic        room2,
	output token_word_t token_word,
	output logic        token_valid,
	input  logic        token_stall
);

	token_word_t       mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign token_valid = count_q != '0;
	assign token_word  = mem[rd_ptr_q];
	assign pop         = token_valid && !token_stall;
	assign room2       = count_q <= QCNT_W'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_ptr_q] <= push.w0;
		end
		if (push.n == 2'd2) begin
			mem[wr_ptr_q + QPTR_W'(1)] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("token queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room2)
		else $error("push without room for two tokens");

	a_push_n: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3)
		else $error("illegal push count");

endmodule

// ===== rtl/core/grammar_token_lexer.sv =====
// Grammar token lexer top level: input register, lexer core and token queue.
// Takes one character word per cycle while char_stall is low and returns zero, one or two
// token words for it, in order, with last_of_run set on the final one. A character is
// registered in the input register, then lexed by the core when the queue has room. Tokens
// pass through a four-entry queue; char_stall rises while a registered character waits for
// two free queue slots, so with at most one token per character and no output stall the
// block runs at one character per cycle, and sustained two-token characters run at the
// queue's drain rate of one token per cycle.
module grammar_token_lexer import gtl_pkg::*; #(
	parameter int MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  char_word_t  char_word,
	input  logic        char_valid,
	output logic        char_stall,
	output token_word_t token_word,
	output logic        token_valid,
	input  logic        token_stall
);

	char_word_t  char_s1;
	logic        valid_s1;
	logic        room2;
	logic        fire;
	token_push_t push;

	assign fire       = valid_s1 && room2;
	assign char_stall = valid_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_word;
		end
	end

	gtl_core #(
		.MAX_TEXT_CHARS(MAX_TEXT_CHARS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.ch    (char_s1),
		.push  (push)
	);

	gtl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room2      (room2),
		.token_word (token_word),
		.token_valid(token_valid),
		.token_stall(token_stall)
	);

endmodule
